// ===== rtl/spms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spms_pkg
// Shared types, codes and default sizes for the shared pool multi stack.
// ----------------------------------------------------------------------------
package spms_pkg;

    // fixed payload widths of the channels
    localparam int SEL_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // default sizes
    localparam int DEF_NUM_STACKS  = 4;
    localparam int DEF_POOL_DEPTH  = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_EXEC
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/spms_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spms_if
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spms_in_if;
    import spms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [SEL_W-1:0]         stack_sel;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output func, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input func, input stack_sel, input push_value,
                    output ready);
endinterface

interface spms_out_if;
    import spms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/shared_pool_multi_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shared_pool_multi_stack
// Several LIFO stacks sharing one entry pool through links and a free chain.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: func (0 push, 1 pop), stack_sel and push_value.
//   o_out carries one result per request: pop_value and status
//   (0 ok, 1 overflow on push, 2 underflow on pop). pop_value is 0 unless
//   a pop succeeds.
//   For a push, the stack top and the link of the free head are read from
//   their RAMs in parallel, then the entry is written back. For a pop, the
//   stack top read must finish before the pool entry at that top can be
//   read. The next request is taken in the cycle after the result is
//   loaded, so a new request is never taken before the last one is done.
//   Results sit in an output register; a new request is accepted while a
//   result waits, and the block holds in its write-back step until the
//   receiver takes the previous result.
//   Reset empties every stack and rebuilds the free chain at once: untouched
//   pool entries are tracked by a fill count, stack tops by valid bits, so
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack #(
    parameter int NUM_STACKS  = spms_pkg::DEF_NUM_STACKS,
    parameter int POOL_DEPTH  = spms_pkg::DEF_POOL_DEPTH,
    parameter int VALUE_WIDTH = spms_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spms_in_if.sink    i_in,
    spms_out_if.source o_out
);
    import spms_pkg::*;

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int SEXT_W = SEL_W + STK_W;
    localparam int ENT_W  = VALUE_WIDTH + PTR_W;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

    t_state r_state, n_state;

    // request registers
    logic                   r_func;
    logic [STK_W-1:0]       r_sel;
    logic                   r_sel_ok;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [PTR_W-1:0]       r_slot;

    // list state held in flops
    logic [PTR_W-1:0]      r_free;
    logic [PTR_W-1:0]      r_fill;
    logic [NUM_STACKS-1:0] r_top_vld;

    // output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_pop_value;
    t_status                  r_status;

    // memory ports
    logic             pool_we, pool_re;
    logic [IDX_W-1:0] pool_waddr, pool_raddr;
    logic [ENT_W-1:0] pool_wdata, pool_rdata;
    logic             tops_we, tops_re;
    logic [STK_W-1:0] tops_waddr, tops_raddr;
    logic [PTR_W-1:0] tops_wdata, tops_rdata;

    // decoded request and read data
    logic [SEXT_W-1:0]      in_sel_ext;
    logic [STK_W-1:0]       in_sel;
    logic                   in_sel_ok;
    logic [VALUE_WIDTH+DATA_W-1:0] in_val_ext;
    logic [PTR_W-1:0]       top_code;
    logic [PTR_W-1:0]       rd_link;
    logic [PTR_W-1:0]       free_link;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [VALUE_WIDTH+DATA_W-1:0] rd_value_ext;
    logic                   accept;
    logic                   exec_go;
    logic                   push_ok;
    logic                   pop_ok;

    spms_ram #(.WIDTH(ENT_W), .DEPTH(POOL_DEPTH)) u_pool (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (pool_waddr),
        .i_wdata (pool_wdata),
        .i_re    (pool_re),
        .i_raddr (pool_raddr),
        .o_rdata (pool_rdata)
    );

    spms_ram #(.WIDTH(PTR_W), .DEPTH(NUM_STACKS)) u_tops (
        .i_clk   (i_clk),
        .i_we    (tops_we),
        .i_waddr (tops_waddr),
        .i_wdata (tops_wdata),
        .i_re    (tops_re),
        .i_raddr (tops_raddr),
        .o_rdata (tops_rdata)
    );

    // request decode
    assign accept     = i_in.valid && i_in.ready;
    assign in_sel_ext = {{STK_W{1'b0}}, i_in.stack_sel};
    assign in_sel     = in_sel_ext[STK_W-1:0];
    assign in_sel_ok  = in_sel_ext < SEXT_W'(NUM_STACKS);
    assign in_val_ext = {{VALUE_WIDTH{1'b0}}, i_in.push_value};

    // read data, with invalid or damaged codes treated as null
    assign top_code = (r_top_vld[r_sel] && (tops_rdata < NULL_PTR)) ? tops_rdata : NULL_PTR;
    assign rd_link  = (pool_rdata[PTR_W-1:0] < NULL_PTR) ? pool_rdata[PTR_W-1:0] : NULL_PTR;
    assign rd_value = pool_rdata[PTR_W +: VALUE_WIDTH];
    assign rd_value_ext = {{DATA_W{1'b0}}, rd_value};

    // an untouched entry still links to the next one
    assign free_link = (r_free >= r_fill) ? PTR_W'(r_free + 1'b1) : rd_link;

    assign push_ok = r_sel_ok && (r_free < NULL_PTR);
    assign pop_ok  = r_sel_ok && (r_slot < NULL_PTR);

    // sequencer next state and memory control
    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        exec_go    = 1'b0;
        pool_re    = 1'b0;
        pool_raddr = r_free[IDX_W-1:0];
        tops_re    = 1'b0;
        tops_raddr = in_sel;
        pool_we    = 1'b0;
        pool_waddr = r_free[IDX_W-1:0];
        pool_wdata = {r_val, top_code};
        tops_we    = 1'b0;
        tops_waddr = r_sel;
        tops_wdata = r_free;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    tops_re = 1'b1;
                    pool_re = (i_in.func == FUNC_PUSH);
                    n_state = (i_in.func == FUNC_PUSH) ? S_EXEC : S_TOP;
                end
            end
            S_TOP: begin
                pool_re    = 1'b1;
                pool_raddr = top_code[IDX_W-1:0];
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (!r_out_valid || o_out.ready) begin
                    exec_go = 1'b1;
                    n_state = S_IDLE;
                    if (r_func == FUNC_PUSH) begin
                        pool_we = push_ok;
                        tops_we = push_ok;
                    end else begin
                        pool_we    = pop_ok;
                        pool_waddr = r_slot[IDX_W-1:0];
                        pool_wdata = {rd_value, r_free};
                        tops_we    = pop_ok;
                        tops_wdata = rd_link;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and stack top for pops
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_in.func;
            r_sel    <= in_sel;
            r_sel_ok <= in_sel_ok;
            r_val    <= in_val_ext[VALUE_WIDTH-1:0];
        end
        if (r_state == S_TOP) begin
            r_slot <= top_code;
        end
    end

    // free chain, fill count and top valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= '0;
            r_fill    <= '0;
            r_top_vld <= '0;
        end else if (exec_go) begin
            if (r_func == FUNC_PUSH) begin
                if (push_ok) begin
                    r_free           <= free_link;
                    r_top_vld[r_sel] <= 1'b1;
                    if (r_free == r_fill) begin
                        r_fill <= PTR_W'(r_fill + 1'b1);
                    end
                end
            end else if (pop_ok) begin
                r_free <= r_slot;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            if (r_func == FUNC_PUSH) begin
                r_pop_value <= '0;
                r_status    <= push_ok ? ST_OK : ST_OVERFLOW;
            end else begin
                r_pop_value <= pop_ok ? rd_value_ext[DATA_W-1:0] : '0;
                r_status    <= pop_ok ? ST_OK : ST_UNDERFLOW;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pop_value = r_pop_value;
    assign o_out.status    = r_status;

endmodule
`default_nettype wire

// ===== rtl/spms_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spms_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spms_checker
// Port-level checks on the result channel of the shared pool multi stack.
// ----------------------------------------------------------------------------
module spms_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [spms_pkg::DATA_W-1:0]   i_pop_value,
    input wire logic        [spms_pkg::STATUS_W-1:0] i_status
);
    import spms_pkg::*;

    // status is always one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_OVERFLOW ||
                         i_status == ST_UNDERFLOW))
        else $error("undefined status code");

    // errors never carry a value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> (i_pop_value == '0))
        else $error("error result with nonzero value");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a transfer in is followed by no result in the very next cycle unless one waited
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result faster than minimum latency");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pop_value) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind shared_pool_multi_stack spms_checker u_spms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pop_value (o_out.pop_value),
    .i_status    (o_out.status)
);
`default_nettype wire
